>>> sv/etg_pkg.sv
// ----------------------------------------------------------------------------
// etg_pkg
// Shared types and constants of the Euclidean trigger generator.
// ----------------------------------------------------------------------------
package etg_pkg;

   localparam int unsigned TICK_W  = 32;
   localparam int unsigned LEN_W   = 8;
   localparam int unsigned DEST_W  = 5;
   localparam int unsigned PITCH_W = 7;
   localparam int unsigned CSR_IDX_W = 3;

   // Ticks per step; the serial divider etg_step_div is built around this value.
   localparam logic [2:0] STEP_TICKS = 3'd6;

   localparam logic [DEST_W-1:0]  LAST_PIN_DEST   = 5'd5;
   localparam logic [DEST_W-1:0]  FIRST_NOTE_DEST = 5'd6;
   localparam logic [DEST_W-1:0]  END_NOTE_DEST   = 5'd22;
   localparam logic [PITCH_W-1:0] NOTE_ON_VELOCITY = 7'd127;
   localparam logic [PITCH_W-1:0] PITCH_RESET      = 7'd60;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_DESTINATION    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LENGTH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HITS_FIRST     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_FIRST   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HITS_SECOND    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_SECOND  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_GATE_TICKS     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_NOTE_PITCH     = 3'd7;

   // Result codes
   localparam logic [1:0] EVENT_NONE  = 2'd0;
   localparam logic [1:0] EVENT_START = 2'd1;
   localparam logic [1:0] EVENT_STOP  = 2'd2;

   localparam logic [1:0] TARGET_NONE = 2'd0;
   localparam logic [1:0] TARGET_GATE = 2'd1;
   localparam logic [1:0] TARGET_NOTE = 2'd2;

   typedef struct packed {
      logic             done;
      logic             on_step;
      logic [LEN_W-1:0] step_mod;
   } step_status_type;

   typedef struct packed {
      logic done;
      logic hit;
   } lane_status_type;

endpackage

>>> sv/etg_step_div.sv
// ----------------------------------------------------------------------------
// etg_step_div
// Bit-serial divide of the tick count by six; the quotient is reduced modulo
// the pattern length on the fly.
// ----------------------------------------------------------------------------
module etg_step_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [etg_pkg::TICK_W-1:0]      tick,
   input  logic [etg_pkg::LEN_W-1:0]       length,
   output etg_pkg::step_status_type        status
);

   logic [etg_pkg::TICK_W-1:0] tick_sr_ff, tick_sr_in;
   logic [2:0]                 rem_ff, rem_in;
   logic [etg_pkg::LEN_W-1:0]  qmod_ff, qmod_in;
   logic [4:0]                 cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;

   logic [3:0]               rem_wide;
   logic                     qbit;
   logic [etg_pkg::LEN_W:0]  qmod_wide;

   always_comb begin
      rem_wide  = {rem_ff, tick_sr_ff[etg_pkg::TICK_W-1]};
      qbit      = (rem_wide >= {1'b0, etg_pkg::STEP_TICKS});
      qmod_wide = {qmod_ff, qbit};

      tick_sr_in = tick_sr_ff;
      rem_in     = rem_ff;
      qmod_in    = qmod_ff;
      cnt_in     = cnt_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;

      if (start) begin
         tick_sr_in = tick;
         rem_in     = '0;
         qmod_in    = '0;
         cnt_in     = '0;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         // advance one tick bit, MSB first
         tick_sr_in = {tick_sr_ff[etg_pkg::TICK_W-2:0], 1'b0};
         rem_in     = qbit ? 3'(rem_wide - {1'b0, etg_pkg::STEP_TICKS}) : rem_wide[2:0];
         if (qmod_wide >= {1'b0, length}) begin
            qmod_in = etg_pkg::LEN_W'(qmod_wide - {1'b0, length});
         end else begin
            qmod_in = qmod_wide[etg_pkg::LEN_W-1:0];
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      tick_sr_ff <= tick_sr_in;
      rem_ff     <= rem_in;
      qmod_ff    <= qmod_in;
      cnt_ff     <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.done     = done_ff;
   assign status.on_step  = (rem_ff == 3'd0);
   assign status.step_mod = qmod_ff;

endmodule

>>> sv/etg_hit_lane.sv
// ----------------------------------------------------------------------------
// etg_hit_lane
// One Euclidean pattern test: offset mod length, then hits * position mod
// length, both bit-serial.
// ----------------------------------------------------------------------------
module etg_hit_lane (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [etg_pkg::LEN_W-1:0]   length,
   input  logic [etg_pkg::LEN_W-1:0]   hits,
   input  logic [etg_pkg::LEN_W-1:0]   offset,
   input  logic [etg_pkg::LEN_W-1:0]   step_mod,
   output etg_pkg::lane_status_type    status
);

   localparam int unsigned W = etg_pkg::LEN_W;

   logic [W-1:0] off_sr_ff, off_sr_in;
   logic [W-1:0] hit_sr_ff, hit_sr_in;
   logic [W-1:0] acc_ff, acc_in;
   logic [W-1:0] pos_ff, pos_in;
   logic [3:0]   cnt_ff, cnt_in;
   logic         busy_ff, busy_in;
   logic         done_ff, done_in;

   logic [W:0]   red_wide, red_dbl, red_sum, pos_wide;
   logic [W-1:0] red_val, dbl_val, sum_val, pos_val;

   always_comb begin
      // offset reduction step
      red_wide = {acc_ff, off_sr_ff[W-1]};
      red_val  = (red_wide >= {1'b0, length}) ? W'(red_wide - {1'b0, length})
                                              : red_wide[W-1:0];
      // position from the reduced offset
      pos_wide = (W+1)'({1'b0, length} - {1'b0, red_val}) + {1'b0, step_mod};
      pos_val  = (pos_wide >= {1'b0, length}) ? W'(pos_wide - {1'b0, length})
                                              : pos_wide[W-1:0];
      // multiply step: double, then add position
      red_dbl = {acc_ff, 1'b0};
      dbl_val = (red_dbl >= {1'b0, length}) ? W'(red_dbl - {1'b0, length})
                                            : red_dbl[W-1:0];
      red_sum = {1'b0, dbl_val} + (hit_sr_ff[W-1] ? {1'b0, pos_ff} : '0);
      sum_val = (red_sum >= {1'b0, length}) ? W'(red_sum - {1'b0, length})
                                            : red_sum[W-1:0];

      off_sr_in = off_sr_ff;
      hit_sr_in = hit_sr_ff;
      acc_in    = acc_ff;
      pos_in    = pos_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;

      if (start) begin
         off_sr_in = offset;
         hit_sr_in = hits;
         acc_in    = '0;
         cnt_in    = '0;
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 4'd1;
         if (!cnt_ff[3]) begin
            off_sr_in = {off_sr_ff[W-2:0], 1'b0};
            acc_in    = red_val;
            if (cnt_ff[2:0] == 3'd7) begin
               // hand over to the multiply phase
               pos_in = pos_val;
               acc_in = '0;
            end
         end else begin
            hit_sr_in = {hit_sr_ff[W-2:0], 1'b0};
            acc_in    = sum_val;
            if (cnt_ff[2:0] == 3'd7) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      off_sr_ff <= off_sr_in;
      hit_sr_ff <= hit_sr_in;
      acc_ff    <= acc_in;
      pos_ff    <= pos_in;
      cnt_ff    <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.done = done_ff;
   assign status.hit  = (acc_ff < hits);

endmodule

>>> sv/euclidean_trigger_generator.sv
// ----------------------------------------------------------------------------
// euclidean_trigger_generator
// Two Euclidean rhythm patterns sharing one length turn tick beats into gate
// pin or note start/stop events.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_stall  tick_count, new_tick
//   rsp_     out        rsp_valid/rsp_stall  event_kind, target_kind, pin_index,
//                                            note_channel, note_number,
//                                            note_velocity
//   csr_     in         csr_write            csr_index, csr_data
//
// From acceptance to the output register: an idle beat (block off or stale
// tick) goes straight to the load; else a divider kick, 32-bit serial divide
// by six, status read and load, plus on a step tick the two pattern lanes
// (offset reduce, multiply, hit collect). Reset is synchronous and clears the
// control, pulse and config state (pitch to 60), not tick or payload. req_stall
// is high during a beat; a result waits in the output register under rsp_stall.
// ----------------------------------------------------------------------------
module euclidean_trigger_generator (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [etg_pkg::TICK_W-1:0]            req_tick_count,
   input  logic                                  req_new_tick,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [1:0]                            rsp_event_kind,
   output logic [1:0]                            rsp_target_kind,
   output logic [2:0]                            rsp_pin_index,
   output logic [4:0]                            rsp_note_channel,
   output logic [6:0]                            rsp_note_number,
   output logic [6:0]                            rsp_note_velocity,
   // configuration port
   input  logic                                  csr_write,
   input  logic [etg_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [etg_pkg::LEN_W-1:0]             csr_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_HIT,
      ST_RESULT
   } state_type;

   // configuration
   logic [etg_pkg::DEST_W-1:0]  dest_ff;
   logic [etg_pkg::LEN_W-1:0]   length_ff, hits1_ff, off1_ff, hits2_ff, off2_ff, gate_ff;
   logic [etg_pkg::PITCH_W-1:0] pitch_ff;

   // control
   state_type                   state_ff, state_in;
   logic [etg_pkg::TICK_W-1:0]  tick_ff, tick_in;
   logic                        enabled_ff, enabled_in;
   logic                        hit_ff, hit_in;
   // marks that the divider was started for the beat in ST_DIV
   logic                        div_busy_seen_ff;

   // pulse state
   logic [etg_pkg::TICK_W-1:0]  start_tick_ff, start_tick_in;
   logic [etg_pkg::PITCH_W-1:0] held_pitch_ff, held_pitch_in;
   logic [etg_pkg::DEST_W-1:0]  held_dest_ff, held_dest_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  event_ff, event_in, target_ff, target_in;
   logic [2:0]  pin_ff, pin_in;
   logic [4:0]  chan_ff, chan_in;
   logic [6:0]  num_ff, num_in, vel_ff, vel_in;

   logic                       accept, out_free, div_start, lane_start;
   logic                       is_pin, is_note, held_is_note, stop_now;
   logic [etg_pkg::DEST_W-1:0] stop_dest;
   etg_pkg::step_status_type   div_status;
   etg_pkg::lane_status_type   lane1_status, lane2_status;

   etg_step_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .tick   (tick_ff),
      .length (length_ff),
      .status (div_status)
   );

   etg_hit_lane u_lane_first (
      .clock    (clock),
      .reset    (reset),
      .start    (lane_start),
      .length   (length_ff),
      .hits     (hits1_ff),
      .offset   (off1_ff),
      .step_mod (div_status.step_mod),
      .status   (lane1_status)
   );

   etg_hit_lane u_lane_second (
      .clock    (clock),
      .reset    (reset),
      .start    (lane_start),
      .length   (length_ff),
      .hits     (hits2_ff),
      .offset   (off2_ff),
      .step_mod (div_status.step_mod),
      .status   (lane2_status)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign is_pin  = (dest_ff >= 5'd1) && (dest_ff <= etg_pkg::LAST_PIN_DEST);
   assign is_note = (dest_ff >= etg_pkg::FIRST_NOTE_DEST) && (dest_ff < etg_pkg::END_NOTE_DEST);
   assign held_is_note = (held_dest_ff >= etg_pkg::FIRST_NOTE_DEST)
                      && (held_dest_ff < etg_pkg::END_NOTE_DEST);
   // fall back to the current destination when no note was ever started
   assign stop_dest = held_is_note ? held_dest_ff : dest_ff;
   assign stop_now  = (tick_ff == (start_tick_ff + {24'd0, gate_ff}));

   always_comb begin
      state_in      = state_ff;
      tick_in       = tick_ff;
      enabled_in    = enabled_ff;
      hit_in        = hit_ff;
      start_tick_in = start_tick_ff;
      held_pitch_in = held_pitch_ff;
      held_dest_in  = held_dest_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      event_in      = event_ff;
      target_in     = target_ff;
      pin_in        = pin_ff;
      chan_in       = chan_ff;
      num_in        = num_ff;
      vel_in        = vel_ff;
      div_start     = 1'b0;
      lane_start    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               tick_in    = req_tick_count;
               enabled_in = req_new_tick && (dest_ff != '0) && (length_ff != '0)
                         && (hits1_ff != '0);
               hit_in     = 1'b0;
               // skip the arithmetic for an idle beat
               state_in   = enabled_in ? ST_DIV : ST_RESULT;
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               if (div_status.on_step) begin
                  lane_start = 1'b1;
                  state_in   = ST_HIT;
               end else begin
                  state_in = ST_RESULT;
               end
            end else begin
               // kick the divider on the first cycle only
               div_start = !div_busy_seen_ff;
            end
         end
         ST_HIT: begin
            if (lane1_status.done) begin
               hit_in   = lane1_status.hit || lane2_status.hit;
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               event_in     = etg_pkg::EVENT_NONE;
               target_in    = etg_pkg::TARGET_NONE;
               pin_in       = '0;
               chan_in      = '0;
               num_in       = '0;
               vel_in       = '0;
               if (enabled_ff && hit_ff) begin
                  // pulse start; a silent destination still records the tick
                  start_tick_in = tick_ff;
                  if (is_pin) begin
                     event_in  = etg_pkg::EVENT_START;
                     target_in = etg_pkg::TARGET_GATE;
                     pin_in    = 3'(dest_ff - 5'd1);
                  end else if (is_note) begin
                     held_dest_in  = dest_ff;
                     held_pitch_in = pitch_ff;
                     event_in      = etg_pkg::EVENT_START;
                     target_in     = etg_pkg::TARGET_NOTE;
                     chan_in       = dest_ff - etg_pkg::LAST_PIN_DEST;
                     num_in        = pitch_ff;
                     vel_in        = etg_pkg::NOTE_ON_VELOCITY;
                  end
               end else if (enabled_ff && stop_now) begin
                  if (is_pin) begin
                     event_in  = etg_pkg::EVENT_STOP;
                     target_in = etg_pkg::TARGET_GATE;
                     pin_in    = 3'(dest_ff - 5'd1);
                  end else if (is_note) begin
                     event_in  = etg_pkg::EVENT_STOP;
                     target_in = etg_pkg::TARGET_NOTE;
                     chan_in   = stop_dest - etg_pkg::LAST_PIN_DEST;
                     num_in    = held_pitch_ff;
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      tick_ff <= tick_in;
      event_ff  <= event_in;
      target_ff <= target_in;
      pin_ff    <= pin_in;
      chan_ff   <= chan_in;
      num_ff    <= num_in;
      vel_ff    <= vel_in;
      if (reset) begin
         state_ff         <= ST_IDLE;
         enabled_ff       <= 1'b0;
         hit_ff           <= 1'b0;
         div_busy_seen_ff <= 1'b0;
         start_tick_ff    <= '0;
         held_pitch_ff    <= '0;
         held_dest_ff     <= '0;
         rsp_valid_ff     <= 1'b0;
         dest_ff          <= '0;
         length_ff        <= '0;
         hits1_ff         <= '0;
         off1_ff          <= '0;
         hits2_ff         <= '0;
         off2_ff          <= '0;
         gate_ff          <= '0;
         pitch_ff         <= etg_pkg::PITCH_RESET;
      end else begin
         state_ff         <= state_in;
         enabled_ff       <= enabled_in;
         hit_ff           <= hit_in;
         div_busy_seen_ff <= (state_ff == ST_DIV);
         start_tick_ff    <= start_tick_in;
         held_pitch_ff    <= held_pitch_in;
         held_dest_ff     <= held_dest_in;
         rsp_valid_ff     <= rsp_valid_in;
         if (csr_write) begin
            case (csr_index)
               etg_pkg::CSR_DESTINATION:    dest_ff   <= csr_data[etg_pkg::DEST_W-1:0];
               etg_pkg::CSR_PATTERN_LENGTH: length_ff <= csr_data;
               etg_pkg::CSR_HITS_FIRST:     hits1_ff  <= csr_data;
               etg_pkg::CSR_OFFSET_FIRST:   off1_ff   <= csr_data;
               etg_pkg::CSR_HITS_SECOND:    hits2_ff  <= csr_data;
               etg_pkg::CSR_OFFSET_SECOND:  off2_ff   <= csr_data;
               etg_pkg::CSR_GATE_TICKS:     gate_ff   <= csr_data;
               etg_pkg::CSR_NOTE_PITCH:     pitch_ff  <= csr_data[etg_pkg::PITCH_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_event_kind    = event_ff;
   assign rsp_target_kind   = target_ff;
   assign rsp_pin_index     = pin_ff;
   assign rsp_note_channel  = chan_ff;
   assign rsp_note_number   = num_ff;
   assign rsp_note_velocity = vel_ff;

endmodule
